FILE: design/plc_tmr_pkg.sv
// Package for the PLC timer block: shared types, register indexes and codes.
// Used by the front queue, the back end and the top level.
package plc_tmr_pkg;

    localparam int TICK_W = 32;
    localparam int TIME_W = 16;
    localparam int CNT_W  = 8;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [1:0] CFG_TIMER_MODE    = 2'd0;
    localparam logic [1:0] CFG_PRESET_TIME   = 2'd1;
    localparam logic [1:0] CFG_TICK_PRESCALE = 2'd2;

    localparam logic [1:0] MODE_ON_DELAY  = 2'd0;
    localparam logic [1:0] MODE_OFF_DELAY = 2'd1;
    localparam logic [1:0] MODE_PULSE     = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PULSE = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] tick_count;
        logic             input_level;
    } item_t;

    typedef struct packed {
        logic [1:0]        timer_mode;
        logic [TIME_W-1:0] preset_time;
        logic [TIME_W-1:0] tick_prescale;
    } cfg_t;

endpackage

FILE: design/plc_tmr_ifs.sv
// Handshake channel interfaces for the PLC timer: input items and results.
// No dependencies.
interface plc_tmr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] tick_count;
    logic       input_level;

    modport source (output valid, output command, output tick_count, output input_level,
                    input ready);
    modport sink   (input valid, input command, input tick_count, input input_level,
                    output ready);
endinterface

interface plc_tmr_out_if;
    logic        valid;
    logic        ready;
    logic        timer_output;
    logic [15:0] elapsed_time;

    modport source (output valid, output timer_output, output elapsed_time, input ready);
    modport sink   (input valid, input timer_output, input elapsed_time, output ready);
endinterface

FILE: design/plc_tmr_front.sv
// Front end: accepts input items, classifies the command and queues them.
// Depends on plc_tmr_pkg and plc_tmr_in_if.
module plc_tmr_front (
    input  logic                clk,
    input  logic                rst_n,
    plc_tmr_in_if.sink          item_ch,
    input  logic                pop,
    output logic                head_valid,
    output plc_tmr_pkg::item_t  head
);
    import plc_tmr_pkg::*;

    localparam logic [QPTR_W:0] FULL = (QPTR_W + 1)'(QDEPTH);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              do_pop;
    item_t             item_in;

    assign item_ch.ready = (count_reg != FULL);
    assign push          = item_ch.valid && item_ch.ready;
    assign head_valid    = (count_reg != '0);
    assign do_pop        = pop && head_valid;
    assign head          = mem_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.op          = item_ch.command ? OP_EVAL : OP_TICK;
        item_in.tick_count  = item_ch.tick_count;
        item_in.input_level = item_ch.input_level;
        count_next = count_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/plc_tmr_div.sv
// Restoring divider: 32-bit tick difference by 16-bit prescaler, one bit a cycle.
// Returns the low 16 bits of the quotient. Depends on plc_tmr_pkg.
module plc_tmr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [plc_tmr_pkg::TICK_W-1:0]  dividend,
    input  logic [plc_tmr_pkg::TIME_W-1:0]  divisor,
    output logic                            done,
    output logic [plc_tmr_pkg::TIME_W-1:0]  quotient
);
    import plc_tmr_pkg::*;

    localparam int STEP_W = $clog2(TICK_W + 1);

    logic [TICK_W-1:0] dvd_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   diff;
    logic              ge;

    assign rem_sh   = {rem_reg, dvd_reg[TICK_W-1]};
    assign diff     = rem_sh - {1'b0, divisor};
    assign ge       = (rem_sh >= {1'b0, divisor});
    assign done     = done_reg;
    assign quotient = dvd_reg[TIME_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            dvd_reg <= {dvd_reg[TICK_W-2:0], ge};
            rem_reg <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(TICK_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

FILE: design/plc_tmr_back.sv
// Back end: tick counter, timer state per mode and the result register.
// Depends on plc_tmr_pkg, plc_tmr_div and plc_tmr_out_if.
module plc_tmr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  plc_tmr_pkg::cfg_t   cfg,
    input  logic                head_valid,
    input  plc_tmr_pkg::item_t  head,
    output logic                pop,
    plc_tmr_out_if.source       res_ch
);
    import plc_tmr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POST
    } state_t;

    state_t            state_reg, state_next;
    logic [TICK_W-1:0] tick_counter_reg, tick_counter_next;
    logic [TICK_W-1:0] start_ticks_reg, start_ticks_next;
    logic              running_reg, running_next;
    logic              output_bit_reg, output_bit_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [1:0]        phase_reg, phase_next;
    logic              level_reg, level_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_bit_reg, out_bit_next;
    logic [TIME_W-1:0] out_elapsed_reg, out_elapsed_next;

    logic              slot_free;
    logic              div_start;
    logic              div_done;
    logic [TICK_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] e_meas;

    assign slot_free = !out_valid_reg || res_ch.ready;
    assign divisor   = (cfg.tick_prescale == '0) ? TIME_W'(1) : cfg.tick_prescale;
    assign dividend  = tick_counter_reg - start_ticks_next;

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.timer_output = out_bit_reg;
    assign res_ch.elapsed_time = out_elapsed_reg;

    plc_tmr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (q)
    );

    always_comb
    begin
        state_next        = state_reg;
        tick_counter_next = tick_counter_reg;
        start_ticks_next  = start_ticks_reg;
        running_next      = running_reg;
        output_bit_next   = output_bit_reg;
        elapsed_next      = elapsed_reg;
        phase_next        = phase_reg;
        level_next        = level_reg;
        out_valid_next    = out_valid_reg && !res_ch.ready;
        out_bit_next      = out_bit_reg;
        out_elapsed_next  = out_elapsed_reg;
        pop               = 1'b0;
        div_start         = 1'b0;
        e_meas            = (elapsed_reg < cfg.preset_time) ? q : elapsed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && head.op == OP_TICK)
                begin
                    if (slot_free)
                    begin
                        pop               = 1'b1;
                        tick_counter_next = tick_counter_reg + TICK_W'(head.tick_count);
                        out_valid_next    = 1'b1;
                        out_bit_next      = output_bit_reg;
                        out_elapsed_next  = elapsed_reg;
                    end
                end
                else if (head_valid)
                begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    level_next = head.input_level;
                    state_next = S_DIV;
                    // Latch the start point before measuring
                    unique case (cfg.timer_mode)
                        MODE_ON_DELAY:
                        begin
                            if (head.input_level && !running_reg && !output_bit_reg)
                            begin
                                running_next     = 1'b1;
                                start_ticks_next = tick_counter_reg;
                            end
                        end
                        MODE_OFF_DELAY:
                        begin
                            if (!head.input_level && !running_reg && output_bit_reg)
                            begin
                                running_next     = 1'b1;
                                start_ticks_next = tick_counter_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    unique case (cfg.timer_mode)
                        MODE_ON_DELAY:
                        begin
                            if (!level_reg)
                            begin
                                output_bit_next  = 1'b0;
                                elapsed_next     = '0;
                                running_next     = 1'b0;
                                start_ticks_next = '0;
                            end
                            else if (running_reg)
                            begin
                                if (e_meas >= cfg.preset_time)
                                begin
                                    output_bit_next = 1'b1;
                                    elapsed_next    = cfg.preset_time;
                                end
                                else
                                begin
                                    output_bit_next = 1'b0;
                                    elapsed_next    = e_meas;
                                end
                            end
                        end
                        MODE_OFF_DELAY:
                        begin
                            if (level_reg)
                            begin
                                output_bit_next  = 1'b1;
                                elapsed_next     = '0;
                                running_next     = 1'b0;
                                start_ticks_next = '0;
                            end
                            else if (running_reg)
                            begin
                                if (q >= cfg.preset_time)
                                begin
                                    elapsed_next    = '0;
                                    output_bit_next = 1'b0;
                                    running_next    = 1'b0;
                                end
                                else
                                begin
                                    elapsed_next    = q;
                                    output_bit_next = 1'b1;
                                end
                            end
                        end
                        MODE_PULSE:
                        begin
                            case (phase_reg)
                                PH_IDLE:
                                begin
                                    if (level_reg)
                                    begin
                                        phase_next       = PH_PULSE;
                                        running_next     = 1'b1;
                                        start_ticks_next = tick_counter_reg;
                                        output_bit_next  = 1'b1;
                                    end
                                end
                                PH_PULSE:
                                begin
                                    if (q >= cfg.preset_time)
                                    begin
                                        output_bit_next = 1'b0;
                                        elapsed_next    = '0;
                                        running_next    = 1'b0;
                                        phase_next      = level_reg ? PH_WAIT : PH_IDLE;
                                    end
                                    else
                                    begin
                                        elapsed_next    = q;
                                        output_bit_next = 1'b1;
                                    end
                                end
                                PH_WAIT:
                                begin
                                    if (!level_reg)
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next   = 1'b1;
                    out_bit_next     = output_bit_next;
                    out_elapsed_next = elapsed_next;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tick_counter_reg <= '0;
            start_ticks_reg  <= '0;
            running_reg      <= 1'b0;
            output_bit_reg   <= 1'b0;
            elapsed_reg      <= '0;
            phase_reg        <= PH_IDLE;
            level_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_bit_reg      <= 1'b0;
            out_elapsed_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_counter_reg <= tick_counter_next;
            start_ticks_reg  <= start_ticks_next;
            running_reg      <= running_next;
            output_bit_reg   <= output_bit_next;
            elapsed_reg      <= elapsed_next;
            phase_reg        <= phase_next;
            level_reg        <= level_next;
            out_valid_reg    <= out_valid_next;
            out_bit_reg      <= out_bit_next;
            out_elapsed_reg  <= out_elapsed_next;
        end
    end

endmodule

FILE: design/plc_timer_ton_tof_tp_core.sv
// PLC timer (on-delay, off-delay, pulse). Tick item: result registered at the
// head of the queue; one tick item per cycle while the result slot is free and
// the back end idle. Evaluate item: 32-step restoring divider, then the result;
// no new item meanwhile, while a two-entry queue keeps taking items.
// Reset: tick counter and timer state zero, mode on-delay, preset 0, prescale 1.
module plc_timer_ton_tof_tp_core (
    input  logic        clk,
    input  logic        rst_n,
    plc_tmr_in_if.sink  item_ch,
    plc_tmr_out_if.source res_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import plc_tmr_pkg::*;

    cfg_t  cfg_reg;
    logic  head_valid;
    item_t head;
    logic  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timer_mode    <= MODE_ON_DELAY;
            cfg_reg.preset_time   <= '0;
            cfg_reg.tick_prescale <= TIME_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMER_MODE:    cfg_reg.timer_mode    <= cfg_wdata[1:0];
                CFG_PRESET_TIME:   cfg_reg.preset_time   <= cfg_wdata;
                CFG_TICK_PRESCALE: cfg_reg.tick_prescale <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    plc_tmr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    plc_tmr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_ch     (res_ch)
    );

endmodule
